@@ rtl/core/cau_pkg.sv @@
// ============================================================================
// cau_pkg
// Shared types, constants and helpers of the complex arithmetic unit.
// ============================================================================
`default_nettype none

package cau_pkg;

   // Fixed point format and derived widths
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int TOL_W     = 31;
   localparam int MAG_W     = 64;             // magnitude of any exact intermediate
   localparam int SUM_W     = 66;             // signed sums of two products
   localparam int SAT_W     = MAG_W + 1;      // input width of the saturator
   localparam int DIV_STEPS = DATA_W;         // quotient bits, one per stage
   localparam int DIV_LAT   = DIV_STEPS + 2;  // setup, steps, round/saturate

   typedef enum logic [3:0] {
      ACT_ADD   = 4'd0,
      ACT_SUB   = 4'd1,
      ACT_MUL   = 4'd2,
      ACT_SCALE = 4'd3,
      ACT_DIVS  = 4'd4,
      ACT_DIVC  = 4'd5,
      ACT_DIVA  = 4'd6,
      ACT_CONJ  = 4'd7,
      ACT_MODSQ = 4'd8,
      ACT_EQUAL = 4'd9
   } action_type;

   typedef struct packed {
      logic [3:0]               action;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } cau_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     equal;
      logic                     div_zero;
   } cau_rsp_type;

   // Sign and magnitude to a saturated two's complement word
   function automatic logic [DATA_W-1:0] sat32(input logic neg, input logic [SAT_W-1:0] mag);
      logic [SAT_W-1:0] lim;
      lim = SAT_W'(1) << (DATA_W - 1);
      if (!neg) begin
         sat32 = (mag >= lim) ? DATA_W'(lim - SAT_W'(1)) : mag[DATA_W-1:0];
      end else begin
         sat32 = (mag >= lim) ? DATA_W'(lim) : DATA_W'(-mag[DATA_W-1:0]);
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/cau_divider.sv @@
// ============================================================================
// cau_divider
// Pipelined restoring divider: rounded, saturated (num << FRAC_BITS) / den.
// ============================================================================
`default_nettype none

module cau_divider (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [cau_pkg::MAG_W-1:0]   num_mag,
   input  wire logic                        num_neg,
   input  wire logic [cau_pkg::MAG_W-1:0]   den,
   output logic      [cau_pkg::DATA_W-1:0]  quo
);
   import cau_pkg::*;

   localparam int NUM_W = MAG_W + FRAC_BITS;
   localparam int HI_W  = NUM_W - DIV_STEPS;

   typedef struct packed {
      logic [MAG_W-1:0]     rem;
      logic [DIV_STEPS-1:0] lo;
      logic [DIV_STEPS-1:0] q;
      logic [MAG_W-1:0]     den;
      logic                 neg;
      logic                 ovf;
   } div_stage_type;

   div_stage_type              st_ff [DIV_STEPS+1];
   div_stage_type              st_in [DIV_STEPS+1];
   logic [DATA_W-1:0]          quo_ff;
   logic [DATA_W-1:0]          quo_in;

   // Setup, then one quotient bit per stage
   always_comb begin
      logic [NUM_W-1:0] n_full;
      logic [HI_W-1:0]  hi;
      logic [MAG_W:0]   t;
      logic             ge;
      // high part of the numerator is the first remainder
      n_full       = {num_mag, FRAC_BITS'(0)};
      hi           = n_full[NUM_W-1:DIV_STEPS];
      st_in[0].ovf = MAG_W'(hi) >= den;   // quotient needs more than DIV_STEPS bits
      st_in[0].rem = st_in[0].ovf ? '0 : MAG_W'(hi);
      st_in[0].lo  = n_full[DIV_STEPS-1:0];
      st_in[0].q   = '0;
      st_in[0].den = den;
      st_in[0].neg = num_neg;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         t  = {st_ff[k-1].rem, st_ff[k-1].lo[DIV_STEPS-1]};
         ge = t >= {1'b0, st_ff[k-1].den};
         st_in[k]     = st_ff[k-1];
         st_in[k].rem = ge ? MAG_W'(t - {1'b0, st_ff[k-1].den}) : t[MAG_W-1:0];
         st_in[k].lo  = st_ff[k-1].lo << 1;
         st_in[k].q   = {st_ff[k-1].q[DIV_STEPS-2:0], ge};
      end
   end

   // Round half away from zero, then saturate
   always_comb begin
      logic             rnd;
      logic [DATA_W:0]  q_r;
      rnd = {st_ff[DIV_STEPS].rem, 1'b0} >= {1'b0, st_ff[DIV_STEPS].den};
      q_r = {1'b0, st_ff[DIV_STEPS].q} + (DATA_W + 1)'(rnd);
      if (st_ff[DIV_STEPS].ovf) begin
         quo_in = sat32(st_ff[DIV_STEPS].neg, '1);
      end else begin
         quo_in = sat32(st_ff[DIV_STEPS].neg, SAT_W'(q_r));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

@@ rtl/core/complex_arithmetic_unit.sv @@
// ============================================================================
// complex_arithmetic_unit
// Q16.16 complex ALU: add, sub, mul, scale, three divides, conj, modsq, equal.
// ============================================================================
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   req_     | in        | req_valid/req_stall| action, a_re, a_im, b_re, b_im
//   rsp_     | out       | rsp_valid/rsp_stall| res_re, res_im, equal, div_zero
//   csr_     | in        | csr_wr_en          | tolerance (31 bits)
//
// One request per cycle while req_stall is low. A request passes an input
// register, stages of products, sums and magnitudes, then a 32-stage
// restoring divider (one quotient bit per stage) with setup and rounding.
// Synchronous reset clears valids and sets tolerance to 1.
// A stalled response sits in the output register; one more finished request
// goes to a skid register, and req_stall rises only while the skid is full.
// ============================================================================
`default_nettype none

module complex_arithmetic_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire cau_pkg::cau_req_type        req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output cau_pkg::cau_rsp_type             rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [cau_pkg::TOL_W-1:0]   csr_wr_data
);
   import cau_pkg::*;

   typedef struct packed {
      logic [3:0]               action;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
      logic signed [MAG_W-1:0]  p_rr;   // a_re * b_re
      logic signed [MAG_W-1:0]  p_ii;   // a_im * b_im
      logic signed [MAG_W-1:0]  p_ri;   // a_re * b_im
      logic signed [MAG_W-1:0]  p_ir;   // a_im * b_re
      logic signed [MAG_W-1:0]  p_sx;   // square of a_re or b_re
      logic signed [MAG_W-1:0]  p_sy;   // square of a_im or b_im
   } s1_type;

   typedef struct packed {
      logic [3:0]              action;
      logic signed [SUM_W-1:0] v_re;
      logic signed [SUM_W-1:0] v_im;
      logic signed [SUM_W-1:0] v_den;
   } s2_type;

   typedef struct packed {
      logic [3:0]       action;
      logic             neg_re;
      logic [MAG_W-1:0] mag_re;
      logic             neg_im;
      logic [MAG_W-1:0] mag_im;
      logic             den_neg;
      logic [MAG_W-1:0] den_mag;
      logic             den_zero;
   } s3_type;

   typedef struct packed {
      logic        is_div;
      cau_rsp_type rsp;
   } byp_type;

   logic [TOL_W-1:0]   tol_ff;
   logic               en;
   logic               v0_ff, v1_ff, v2_ff, v3_ff;
   logic [DIV_LAT-1:0] vd_ff;
   cau_req_type        s0_ff;
   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   byp_type            byp_ff [DIV_LAT];
   byp_type            byp_in;
   logic [DATA_W-1:0]  div_re, div_im;
   cau_rsp_type        tail_data;
   logic               tail_v;
   logic               out_take;
   logic               out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   cau_rsp_type        out_ff, out_in, skid_ff, skid_in;

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // Whole pipeline moves while the skid register is empty
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // Stage 1: six products
   always_comb begin
      logic signed [DATA_W-1:0] sq_x, sq_y;
      logic                     sq_a;
      sq_a = (s0_ff.action == ACT_DIVA) || (s0_ff.action == ACT_MODSQ);
      sq_x = sq_a ? s0_ff.a_re : s0_ff.b_re;
      sq_y = sq_a ? s0_ff.a_im : s0_ff.b_im;
      s1_in.action = s0_ff.action;
      s1_in.a_re   = s0_ff.a_re;
      s1_in.a_im   = s0_ff.a_im;
      s1_in.b_re   = s0_ff.b_re;
      s1_in.b_im   = s0_ff.b_im;
      s1_in.p_rr   = MAG_W'(s0_ff.a_re) * MAG_W'(s0_ff.b_re);
      s1_in.p_ii   = MAG_W'(s0_ff.a_im) * MAG_W'(s0_ff.b_im);
      s1_in.p_ri   = MAG_W'(s0_ff.a_re) * MAG_W'(s0_ff.b_im);
      s1_in.p_ir   = MAG_W'(s0_ff.a_im) * MAG_W'(s0_ff.b_re);
      s1_in.p_sx   = MAG_W'(sq_x) * MAG_W'(sq_x);
      s1_in.p_sy   = MAG_W'(sq_y) * MAG_W'(sq_y);
   end

   // Stage 2: exact sums per action
   always_comb begin
      s2_in.action = s1_ff.action;
      s2_in.v_re   = '0;
      s2_in.v_im   = '0;
      s2_in.v_den  = '0;
      case (s1_ff.action)
         ACT_ADD: begin
            s2_in.v_re = SUM_W'(s1_ff.a_re) + SUM_W'(s1_ff.b_re);
            s2_in.v_im = SUM_W'(s1_ff.a_im) + SUM_W'(s1_ff.b_im);
         end
         ACT_SUB, ACT_EQUAL: begin
            s2_in.v_re = SUM_W'(s1_ff.a_re) - SUM_W'(s1_ff.b_re);
            s2_in.v_im = SUM_W'(s1_ff.a_im) - SUM_W'(s1_ff.b_im);
         end
         ACT_MUL: begin
            s2_in.v_re = SUM_W'(s1_ff.p_rr) - SUM_W'(s1_ff.p_ii);
            s2_in.v_im = SUM_W'(s1_ff.p_ri) + SUM_W'(s1_ff.p_ir);
         end
         ACT_SCALE: begin
            s2_in.v_re = SUM_W'(s1_ff.p_rr);
            s2_in.v_im = SUM_W'(s1_ff.p_ir);
         end
         ACT_DIVS: begin
            s2_in.v_re  = SUM_W'(s1_ff.a_re);
            s2_in.v_im  = SUM_W'(s1_ff.a_im);
            s2_in.v_den = SUM_W'(s1_ff.b_re);
         end
         ACT_DIVC: begin
            s2_in.v_re  = SUM_W'(s1_ff.p_rr) + SUM_W'(s1_ff.p_ii);
            s2_in.v_im  = SUM_W'(s1_ff.p_ir) - SUM_W'(s1_ff.p_ri);
            s2_in.v_den = SUM_W'(s1_ff.p_sx) + SUM_W'(s1_ff.p_sy);
         end
         ACT_DIVA: begin
            s2_in.v_re  = SUM_W'(s1_ff.p_rr);
            s2_in.v_im  = -SUM_W'(s1_ff.p_ir);
            s2_in.v_den = SUM_W'(s1_ff.p_sx) + SUM_W'(s1_ff.p_sy);
         end
         ACT_CONJ: begin
            s2_in.v_re = SUM_W'(s1_ff.a_re);
            s2_in.v_im = -SUM_W'(s1_ff.a_im);
         end
         ACT_MODSQ: begin
            s2_in.v_re = SUM_W'(s1_ff.p_sx) + SUM_W'(s1_ff.p_sy);
         end
         default: begin
            s2_in.v_re = '0;
         end
      endcase
   end

   // Stage 3: sign and magnitude
   always_comb begin
      s3_in.action   = s2_ff.action;
      s3_in.neg_re   = s2_ff.v_re[SUM_W-1];
      s3_in.mag_re   = s3_in.neg_re ? MAG_W'(-s2_ff.v_re) : MAG_W'(s2_ff.v_re);
      s3_in.neg_im   = s2_ff.v_im[SUM_W-1];
      s3_in.mag_im   = s3_in.neg_im ? MAG_W'(-s2_ff.v_im) : MAG_W'(s2_ff.v_im);
      s3_in.den_neg  = s2_ff.v_den[SUM_W-1];
      s3_in.den_mag  = s3_in.den_neg ? MAG_W'(-s2_ff.v_den) : MAG_W'(s2_ff.v_den);
      s3_in.den_zero = s2_ff.v_den == '0;
   end

   // Stage 4: results that need no division, carried alongside the divider
   always_comb begin
      logic [SAT_W-1:0] rnd_re, rnd_im;
      rnd_re = {1'b0, s3_ff.mag_re} + (SAT_W'(1) << (FRAC_BITS - 1));
      rnd_im = {1'b0, s3_ff.mag_im} + (SAT_W'(1) << (FRAC_BITS - 1));
      byp_in = '0;
      case (s3_ff.action)
         ACT_ADD, ACT_SUB, ACT_CONJ: begin
            byp_in.rsp.res_re = sat32(s3_ff.neg_re, {1'b0, s3_ff.mag_re});
            byp_in.rsp.res_im = sat32(s3_ff.neg_im, {1'b0, s3_ff.mag_im});
         end
         ACT_MUL, ACT_SCALE, ACT_MODSQ: begin
            byp_in.rsp.res_re = sat32(s3_ff.neg_re, rnd_re >> FRAC_BITS);
            byp_in.rsp.res_im = sat32(s3_ff.neg_im, rnd_im >> FRAC_BITS);
         end
         ACT_DIVS, ACT_DIVC, ACT_DIVA: begin
            byp_in.is_div       = !s3_ff.den_zero;
            byp_in.rsp.div_zero = s3_ff.den_zero;
         end
         ACT_EQUAL: begin
            byp_in.rsp.equal = (s3_ff.mag_re <= MAG_W'(tol_ff)) &&
                               (s3_ff.mag_im <= MAG_W'(tol_ff));
         end
         default: begin
            byp_in = '0;
         end
      endcase
   end

   cau_divider u_div_re (
      .clock   (clock),
      .en      (en),
      .num_mag (s3_ff.mag_re),
      .num_neg (s3_ff.neg_re ^ s3_ff.den_neg),
      .den     (s3_ff.den_mag),
      .quo     (div_re)
   );

   cau_divider u_div_im (
      .clock   (clock),
      .en      (en),
      .num_mag (s3_ff.mag_im),
      .num_neg (s3_ff.neg_im ^ s3_ff.den_neg),
      .den     (s3_ff.den_mag),
      .quo     (div_im)
   );

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff     <= req_data;
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s3_ff     <= s3_in;
         byp_ff[0] <= byp_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            byp_ff[i] <= byp_ff[i-1];
         end
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vd_ff <= '0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vd_ff <= {vd_ff[DIV_LAT-2:0], v3_ff};
      end
   end

   // Merge divider quotients at the tail
   always_comb begin
      tail_v    = vd_ff[DIV_LAT-1];
      tail_data = byp_ff[DIV_LAT-1].rsp;
      if (byp_ff[DIV_LAT-1].is_div) begin
         tail_data.res_re = div_re;
         tail_data.res_im = div_im;
      end
   end

   // Output register with skid
   assign out_take = !out_v_ff || !rsp_stall;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (out_take) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (out_take) begin
         out_v_in = tail_v;
         out_in   = tail_data;
      end else if (tail_v) begin
         skid_v_in = 1'b1;
         skid_in   = tail_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

@@ rtl/core/cau_checker.sv @@
// ============================================================================
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ============================================================================
`default_nettype none

module cau_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire cau_pkg::cau_rsp_type rsp_data
);
   import cau_pkg::*;

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Back pressure only follows a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without response stall");

   // A zero divisor gives a zero result and no compare flag
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |->
         rsp_data.res_re == '0 && rsp_data.res_im == '0 && !rsp_data.equal)
      else $error("zero divisor result not cleared");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("output active after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
